/* rtl/dhs_pkg.sv */
// Package for the defrost heater sequencer: word and register structs,
// register index codes and reset values. No dependencies.
`default_nettype none
package dhs_pkg;

    localparam int DEFAULT_TIME_WIDTH = 16;
    localparam int CFG_WIDTH          = 16;
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam logic [7:0] OVERTIME_MAX = 8'hFF;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_HEATER_TIMEOUT = 3'd0,
        CFG_DRIP_TIMEOUT   = 3'd1,
        CFG_RECHECK_DELAY  = 3'd2,
        CFG_WARM_THRESHOLD = 3'd3,
        CFG_COLD_THRESHOLD = 3'd4,
        CFG_ERROR_LIMIT    = 3'd5,
        CFG_FAULT_MIN_ON   = 3'd6,
        CFG_FAULT_MAX_ON   = 3'd7
    } cfg_index_t;

    localparam logic [15:0]       RST_HEATER_TIMEOUT = 16'd900;
    localparam logic [15:0]       RST_DRIP_TIMEOUT   = 16'd600;
    localparam logic [15:0]       RST_RECHECK_DELAY  = 16'd120;
    localparam logic signed [7:0] RST_WARM_THRESHOLD = 8'sd10;
    localparam logic signed [7:0] RST_COLD_THRESHOLD = 8'sd0;
    localparam logic [7:0]        RST_ERROR_LIMIT    = 8'd2;
    localparam logic [15:0]       RST_FAULT_MIN_ON   = 16'd120;
    localparam logic [15:0]       RST_FAULT_MAX_ON   = 16'd600;

    typedef struct packed {
        logic [15:0]       heater_timeout;
        logic [15:0]       drip_timeout;
        logic [15:0]       recheck_delay;
        logic signed [7:0] warm_threshold;
        logic signed [7:0] cold_threshold;
        logic [7:0]        error_limit;
        logic [15:0]       fault_min_on;
        logic [15:0]       fault_max_on;
    } cfg_t;

    typedef struct packed {
        logic [15:0]       now_seconds;
        logic              in_defrost;
        logic              evap_sensor_fault;
        logic signed [7:0] evap_temp;
        logic [15:0]       compressor_run_time;
    } in_item_t;

    typedef struct packed {
        logic heater_on;
        logic defrost_finished;
        logic heat_error;
        logic beep_request;
    } out_item_t;

endpackage
`default_nettype wire

/* rtl/dhs_if.sv */
// Valid/ready channel interfaces for the sequencer's input and result words.
// No dependencies.
`default_nettype none
interface dhs_in_if;
    logic              valid;
    logic              ready;
    logic [15:0]       now_seconds;
    logic              in_defrost;
    logic              evap_sensor_fault;
    logic signed [7:0] evap_temp;
    logic [15:0]       compressor_run_time;

    modport source (output valid, now_seconds, in_defrost, evap_sensor_fault,
                    evap_temp, compressor_run_time, input ready);
    modport sink   (input valid, now_seconds, in_defrost, evap_sensor_fault,
                    evap_temp, compressor_run_time, output ready);
endinterface

interface dhs_out_if;
    logic valid;
    logic ready;
    logic heater_on;
    logic defrost_finished;
    logic heat_error;
    logic beep_request;

    modport source (output valid, heater_on, defrost_finished, heat_error,
                    beep_request, input ready);
    modport sink   (input valid, heater_on, defrost_finished, heat_error,
                    beep_request, output ready);
endinterface
`default_nettype wire

/* rtl/dhs_cfg.sv */
// Configuration register file of the defrost heater sequencer.
// Depends on dhs_pkg.
`default_nettype none
module dhs_cfg (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wen,
    input  wire logic [dhs_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [dhs_pkg::CFG_WIDTH-1:0]        cfg_data,
    output dhs_pkg::cfg_t                             cfg
);

    dhs_pkg::cfg_t cfg_reg;
    dhs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (dhs_pkg::cfg_index_t'(cfg_index))
                dhs_pkg::CFG_HEATER_TIMEOUT: cfg_next.heater_timeout = cfg_data;
                dhs_pkg::CFG_DRIP_TIMEOUT:   cfg_next.drip_timeout   = cfg_data;
                dhs_pkg::CFG_RECHECK_DELAY:  cfg_next.recheck_delay  = cfg_data;
                dhs_pkg::CFG_WARM_THRESHOLD: cfg_next.warm_threshold = cfg_data[7:0];
                dhs_pkg::CFG_COLD_THRESHOLD: cfg_next.cold_threshold = cfg_data[7:0];
                dhs_pkg::CFG_ERROR_LIMIT:    cfg_next.error_limit    = cfg_data[7:0];
                dhs_pkg::CFG_FAULT_MIN_ON:   cfg_next.fault_min_on   = cfg_data;
                dhs_pkg::CFG_FAULT_MAX_ON:   cfg_next.fault_max_on   = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heater_timeout <= dhs_pkg::RST_HEATER_TIMEOUT;
            cfg_reg.drip_timeout   <= dhs_pkg::RST_DRIP_TIMEOUT;
            cfg_reg.recheck_delay  <= dhs_pkg::RST_RECHECK_DELAY;
            cfg_reg.warm_threshold <= dhs_pkg::RST_WARM_THRESHOLD;
            cfg_reg.cold_threshold <= dhs_pkg::RST_COLD_THRESHOLD;
            cfg_reg.error_limit    <= dhs_pkg::RST_ERROR_LIMIT;
            cfg_reg.fault_min_on   <= dhs_pkg::RST_FAULT_MIN_ON;
            cfg_reg.fault_max_on   <= dhs_pkg::RST_FAULT_MAX_ON;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* rtl/dhs_step.sv */
// Sequencer state registers and the one-word update logic.
// Depends on dhs_pkg.
`default_nettype none
module dhs_step #(
    parameter int TIME_WIDTH = dhs_pkg::DEFAULT_TIME_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire dhs_pkg::in_item_t  item,
    input  wire dhs_pkg::cfg_t      cfg,
    output dhs_pkg::out_item_t      result
);

    localparam int TW = TIME_WIDTH;
    // compare width: sums keep their carry, 16-bit registers fit as well
    localparam int CW = (TW + 1 > 17) ? TW + 1 : 17;

    logic          heater_reg, heater_next;
    logic [TW-1:0] stamp_reg, stamp_next;
    logic [TW-1:0] on_reg, on_next;
    logic [TW-1:0] drip_reg, drip_next;
    logic [7:0]    overtime_reg, overtime_next;
    logic          error_reg, error_next;

    logic [TW-1:0] now_w;
    logic [TW-1:0] elapsed;
    logic [TW:0]   on_sum;
    logic [TW:0]   drip_sum;
    logic [7:0]    overtime_inc;
    logic          over;
    logic          warm;
    logic          fault_done;
    logic          drip_done;
    logic          do_on;
    logic          do_off;
    logic          do_fin;
    logic          do_mark;
    logic          finished;
    logic          beep;

    assign now_w    = TW'(item.now_seconds);
    assign elapsed  = (stamp_reg != '0) ? (now_w - stamp_reg) : '0;
    assign on_sum   = {1'b0, on_reg} + {1'b0, elapsed};
    assign drip_sum = {1'b0, drip_reg} + {1'b0, elapsed};

    assign over      = CW'(on_sum) > CW'(cfg.heater_timeout);
    assign warm      = $signed(item.evap_temp) > $signed(cfg.warm_threshold);
    assign drip_done = CW'(drip_sum) > CW'(cfg.drip_timeout);
    assign fault_done = (CW'(on_sum) > CW'(cfg.fault_min_on)
                         && CW'(on_sum) > CW'(item.compressor_run_time >> 1))
                        || CW'(on_sum) > CW'(cfg.fault_max_on);
    assign overtime_inc = (overtime_reg != dhs_pkg::OVERTIME_MAX)
                          ? overtime_reg + 8'd1 : overtime_reg;

    always_comb
    begin
        do_on         = 1'b0;
        do_off        = 1'b0;
        do_fin        = 1'b0;
        do_mark       = 1'b0;
        beep          = 1'b0;
        overtime_next = overtime_reg;
        error_next    = error_reg;
        if (item.in_defrost)
        begin
            priority if (item.evap_sensor_fault)
            begin
                priority if (heater_reg)
                    do_off = fault_done;
                else if (on_reg == '0)
                    do_on = 1'b1;
                else
                    do_fin = drip_done;
            end
            else if (heater_reg)
            begin
                if (warm || over)
                begin
                    do_off = 1'b1;
                    if (over)
                    begin
                        overtime_next = overtime_inc;
                        if (overtime_inc >= cfg.error_limit && !error_reg)
                        begin
                            error_next = 1'b1;
                            beep       = 1'b1;
                        end
                    end
                    else
                    begin
                        overtime_next = '0;
                        error_next    = 1'b0;
                    end
                end
            end
            else if (on_reg == '0)
            begin
                do_mark = warm;
                do_on   = !warm;
            end
            else if (drip_done)
                do_fin = 1'b1;
            else
                do_on = CW'(on_reg) < CW'(cfg.heater_timeout)
                        && CW'(elapsed) > CW'(cfg.recheck_delay)
                        && $signed(item.evap_temp) <= $signed(cfg.cold_threshold);
        end
    end

    always_comb
    begin
        heater_next = heater_reg;
        stamp_next  = stamp_reg;
        on_next     = on_reg;
        drip_next   = drip_reg;
        finished    = 1'b0;
        priority if (do_on)
        begin
            heater_next = 1'b1;
            drip_next   = drip_reg + elapsed;
            if (on_reg == '0)
                on_next = TW'(1);
            stamp_next  = now_w;
        end
        else if (do_off)
        begin
            heater_next = 1'b0;
            on_next     = on_reg + elapsed;
            if (drip_reg == '0)
                drip_next = TW'(1);
            stamp_next  = now_w;
        end
        else if (do_fin)
        begin
            on_next    = '0;
            drip_next  = '0;
            stamp_next = '0;
            finished   = 1'b1;
        end
        else
        begin
            if (do_mark)
            begin
                on_next    = TW'(1);
                stamp_next = now_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg   <= 1'b0;
            stamp_reg    <= '0;
            on_reg       <= '0;
            drip_reg     <= '0;
            overtime_reg <= '0;
            error_reg    <= 1'b0;
        end
        else if (fire)
        begin
            heater_reg   <= heater_next;
            stamp_reg    <= stamp_next;
            on_reg       <= on_next;
            drip_reg     <= drip_next;
            overtime_reg <= overtime_next;
            error_reg    <= error_next;
        end
    end

    assign result.heater_on        = heater_next;
    assign result.defrost_finished = finished;
    assign result.heat_error       = error_next;
    assign result.beep_request     = beep;

endmodule
`default_nettype wire

/* rtl/defrost_heater_sequencer_core.sv */
// Top level of the defrost heater sequencer: input word register, step logic
// and result register. Depends on dhs_pkg, dhs_if, dhs_cfg and dhs_step.
//
// Usage:
//   item_ch   valid/ready input channel, one word per idle tick: seconds count,
//             defrost and sensor-fault flags, evaporator temperature and
//             compressor run time.
//   result_ch valid/ready output channel, exactly one result word per input
//             word, in order: heater level, defrost-finished pulse, latched
//             heat error and beep pulse.
//   cfg_*     plain write port; cfg_index selects the register, cfg_data
//             carries the value (8-bit registers take the low byte). Write
//             only while no word is in flight.
// Path: an accepted word waits in the input register until the result register can
//   advance; then its result is registered there and is valid until its handshake.
// Throughput: one word per cycle while result_ch is ready; the sequencer state
//   update is a single compare-and-select pass between the input and result registers.
// Reset (rst_n low, asynchronous): heater off, timers and error cleared,
//   registers at their defaults, both channels empty.
// Stall: while result_ch is not ready the result word holds; the input
//   register takes one more word if it is empty, then item_ch.ready drops.
`default_nettype none
module defrost_heater_sequencer_core #(
    parameter int TIME_WIDTH = dhs_pkg::DEFAULT_TIME_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    dhs_in_if.sink                                   item_ch,
    dhs_out_if.source                                result_ch,
    input  wire logic                                cfg_wen,
    input  wire logic [dhs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [dhs_pkg::CFG_WIDTH-1:0]       cfg_data
);

    dhs_pkg::cfg_t      cfg;
    dhs_pkg::in_item_t  item_reg;
    dhs_pkg::out_item_t result_reg;
    dhs_pkg::out_item_t result_next;
    logic               item_valid_reg;
    logic               result_valid_reg;
    logic               advance;
    logic               fire;
    logic               take;

    // Advance the result register whenever it is empty or being drained.
    assign advance = !result_valid_reg || result_ch.ready;
    assign fire    = item_valid_reg && advance;
    assign take    = !item_valid_reg || advance;

    assign item_ch.ready = take;

    dhs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dhs_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result_next)
    );

    // Input word register: load whenever the stage is free or moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (take)
            item_valid_reg <= item_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take && item_ch.valid)
        begin
            item_reg.now_seconds         <= item_ch.now_seconds;
            item_reg.in_defrost          <= item_ch.in_defrost;
            item_reg.evap_sensor_fault   <= item_ch.evap_sensor_fault;
            item_reg.evap_temp           <= item_ch.evap_temp;
            item_reg.compressor_run_time <= item_ch.compressor_run_time;
        end
    end

    // Result register: capture the step output as the state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    assign result_ch.valid            = result_valid_reg;
    assign result_ch.heater_on        = result_reg.heater_on;
    assign result_ch.defrost_finished = result_reg.defrost_finished;
    assign result_ch.heat_error       = result_reg.heat_error;
    assign result_ch.beep_request     = result_reg.beep_request;

`ifndef SYNTHESIS
    // A beep only comes with the error flag it announces.
    a_beep_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.beep_request |-> result_ch.heat_error)
        else $error("beep without heat error");

    // A finished defrost leaves the heater off and cannot beep.
    a_finish_heater_off: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.defrost_finished
        |-> !result_ch.heater_on && !result_ch.beep_request)
        else $error("defrost finished with heater on or beep");

    // A held input word stays in the register until it moves on.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled input word lost");
`endif

endmodule
`default_nettype wire

/* verif/defrost_heater_sequencer_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for defrost_heater_sequencer_core: sends input words with
// random gaps and stalls, predicts every result word and checks it in order.
// Depends on dhs_pkg, the channel interfaces in dhs_if and the core RTL.
module defrost_heater_sequencer_core_tb;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_GAP       = 11;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 200;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wen;
    dhs_pkg::cfg_index_t           cfg_index;
    logic [dhs_pkg::CFG_WIDTH-1:0] cfg_data;

    dhs_in_if  item_if ();
    dhs_out_if result_if ();

    defrost_heater_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_if),
        .result_ch (result_if),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the sequencer: registers and state after every accepted word.
    dhs_pkg::cfg_t cfg_copy;
    logic          heat_on;
    logic [15:0]   stamp;
    logic [15:0]   on_acc;
    logic [15:0]   drip_acc;
    logic [7:0]    overtime;
    logic          err_latched;

    dhs_pkg::out_item_t expected_words[$];

    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned hold_left;
    int unsigned stall_left;
    logic        idle_on;

    // Random stimulus state: a seconds count that moves forward, a drifting
    // evaporator temperature and a sticky sensor-fault flag.
    logic [15:0] gen_now;
    int          gen_temp;
    logic        gen_fault;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Heater switch: fold the elapsed time into the total of the phase that
    // ends, mark the other total as started, and restamp.
    function automatic void switch_heater(logic turn_on, logic [15:0] now_val,
                                          logic [15:0] elapsed);
        if (turn_on == heat_on)
            return;
        heat_on = turn_on;
        if (turn_on)
        begin
            drip_acc = drip_acc + elapsed;
            if (on_acc == 16'd0)
                on_acc = 16'd1;
        end
        else
        begin
            on_acc = on_acc + elapsed;
            if (drip_acc == 16'd0)
                drip_acc = 16'd1;
        end
        stamp = now_val;
    endfunction

    function automatic void end_defrost();
        drip_acc = 16'd0;
        on_acc   = 16'd0;
        stamp    = 16'd0;
    endfunction

    // Advance the shadow state by one word and return the result it causes.
    function automatic dhs_pkg::out_item_t predict_step(dhs_pkg::in_item_t w);
        dhs_pkg::out_item_t res;
        logic [15:0]       elapsed;
        logic [16:0]       on_sum;
        logic [16:0]       drip_sum;
        logic              over;
        logic signed [7:0] temp;
        logic signed [7:0] warm;
        logic signed [7:0] cold;
        res  = '0;
        temp = $signed(w.evap_temp);
        warm = $signed(cfg_copy.warm_threshold);
        cold = $signed(cfg_copy.cold_threshold);
        if (w.in_defrost)
        begin
            // A zero stamp means no phase is being timed.
            elapsed  = (stamp != 16'd0) ? w.now_seconds - stamp : 16'd0;
            on_sum   = {1'b0, on_acc} + {1'b0, elapsed};
            drip_sum = {1'b0, drip_acc} + {1'b0, elapsed};
            if (w.evap_sensor_fault)
            begin
                // Fault mode: heating time tracks half the compressor run time.
                if (heat_on)
                begin
                    if ((on_sum > {1'b0, cfg_copy.fault_min_on} &&
                         on_sum > {2'b00, w.compressor_run_time[15:1]}) ||
                        on_sum > {1'b0, cfg_copy.fault_max_on})
                        switch_heater(1'b0, w.now_seconds, elapsed);
                end
                else if (on_acc == 16'd0)
                    switch_heater(1'b1, w.now_seconds, elapsed);
                else if (drip_sum > {1'b0, cfg_copy.drip_timeout})
                begin
                    end_defrost();
                    res.defrost_finished = 1'b1;
                end
            end
            else if (heat_on)
            begin
                over = on_sum > {1'b0, cfg_copy.heater_timeout};
                if (temp > warm || over)
                begin
                    if (over)
                    begin
                        if (overtime < dhs_pkg::OVERTIME_MAX)
                            overtime = overtime + 8'd1;
                        if (overtime >= cfg_copy.error_limit && !err_latched)
                        begin
                            err_latched      = 1'b1;
                            res.beep_request = 1'b1;
                        end
                    end
                    else
                    begin
                        // Warm finish clears the overtime history.
                        overtime    = 8'd0;
                        err_latched = 1'b0;
                    end
                    switch_heater(1'b0, w.now_seconds, elapsed);
                end
            end
            else if (on_acc == 16'd0)
            begin
                // Already warm at the start: skip heating, go straight to drip.
                if (temp > warm)
                begin
                    on_acc = 16'd1;
                    stamp  = w.now_seconds;
                end
                else
                    switch_heater(1'b1, w.now_seconds, elapsed);
            end
            else if (drip_sum > {1'b0, cfg_copy.drip_timeout})
            begin
                end_defrost();
                res.defrost_finished = 1'b1;
            end
            else if (on_acc < cfg_copy.heater_timeout &&
                     elapsed > cfg_copy.recheck_delay)
            begin
                if (temp <= cold)
                    switch_heater(1'b1, w.now_seconds, elapsed);
            end
        end
        res.heater_on  = heat_on;
        res.heat_error = err_latched;
        return res;
    endfunction

    function automatic dhs_pkg::in_item_t make_word(logic [15:0] now_val, logic defrost,
                                                    logic fault, int temp,
                                                    logic [15:0] crt);
        dhs_pkg::in_item_t w;
        w.now_seconds         = now_val;
        w.in_defrost          = defrost;
        w.evap_sensor_fault   = fault;
        w.evap_temp           = 8'(temp);
        w.compressor_run_time = crt;
        return w;
    endfunction

    // Mostly well-formed defrost traffic: time moves forward, the temperature
    // follows the heater. One word in ten is pure noise.
    function automatic dhs_pkg::in_item_t next_random_word();
        int t;
        if ($urandom_range(0, 9) == 0)
            return make_word(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), int'($urandom_range(0, 255)) - 128,
                             16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 9) < 8)
            gen_now = gen_now + 16'($urandom_range(1, 40));
        else
            gen_now = gen_now + 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 19) == 0)
            gen_fault = ~gen_fault;
        if ($urandom_range(0, 19) == 0)
            t = int'($urandom_range(0, 255)) - 128;
        else if (heat_on)
            t = gen_temp + int'($urandom_range(0, 6)) - 1;
        else
            t = gen_temp + 1 - int'($urandom_range(0, 6));
        if (t > 127)
            t = 127;
        if (t < -128)
            t = -128;
        gen_temp = t;
        return make_word(gen_now, 1'($urandom_range(0, 19) != 0), gen_fault, gen_temp,
                         ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 400)));
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // Offer one word after a random gap; record its prediction once accepted.
    // Valid stays high across back-to-back words, so it is never dropped and
    // raised within one step.
    task automatic send_word(dhs_pkg::in_item_t w);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid               <= 1'b1;
        item_if.now_seconds         <= w.now_seconds;
        item_if.in_defrost          <= w.in_defrost;
        item_if.evap_sensor_fault   <= w.evap_sensor_fault;
        item_if.evap_temp           <= w.evap_temp;
        item_if.compressor_run_time <= w.compressor_run_time;
        forever
        begin
            @(posedge clk);
            if (item_if.ready)
                break;
        end
        expected_words.push_back(predict_step(w));
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic wait_drained();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it; 8-bit registers take the low byte.
    task automatic write_reg(dhs_pkg::cfg_index_t idx, logic [15:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            dhs_pkg::CFG_HEATER_TIMEOUT: cfg_copy.heater_timeout = value;
            dhs_pkg::CFG_DRIP_TIMEOUT:   cfg_copy.drip_timeout   = value;
            dhs_pkg::CFG_RECHECK_DELAY:  cfg_copy.recheck_delay  = value;
            dhs_pkg::CFG_WARM_THRESHOLD: cfg_copy.warm_threshold = value[7:0];
            dhs_pkg::CFG_COLD_THRESHOLD: cfg_copy.cold_threshold = value[7:0];
            dhs_pkg::CFG_ERROR_LIMIT:    cfg_copy.error_limit    = value[7:0];
            dhs_pkg::CFG_FAULT_MIN_ON:   cfg_copy.fault_min_on   = value;
            dhs_pkg::CFG_FAULT_MAX_ON:   cfg_copy.fault_max_on   = value;
            default:                     ;
        endcase
    endtask

    // Write the full register set; junk in the upper byte of 8-bit registers
    // must be dropped by the block.
    task automatic write_all(dhs_pkg::cfg_t c);
        write_reg(dhs_pkg::CFG_HEATER_TIMEOUT, c.heater_timeout);
        write_reg(dhs_pkg::CFG_DRIP_TIMEOUT, c.drip_timeout);
        write_reg(dhs_pkg::CFG_RECHECK_DELAY, c.recheck_delay);
        write_reg(dhs_pkg::CFG_WARM_THRESHOLD,
                  {8'($urandom_range(0, 255)), c.warm_threshold});
        write_reg(dhs_pkg::CFG_COLD_THRESHOLD,
                  {8'($urandom_range(0, 255)), c.cold_threshold});
        write_reg(dhs_pkg::CFG_ERROR_LIMIT, {8'($urandom_range(0, 255)), c.error_limit});
        write_reg(dhs_pkg::CFG_FAULT_MIN_ON, c.fault_min_on);
        write_reg(dhs_pkg::CFG_FAULT_MAX_ON, c.fault_max_on);
    endtask

    // Outside defrost nothing moves: heater level held, no pulses.
    task automatic test_idle_hold();
        send_word(make_word(16'hFFFF, 1'b0, 1'b1, -128, 16'hFFFF));
        send_word(make_word(16'h0000, 1'b0, 1'b0, 127, 16'h0000));
    endtask

    // Reset registers. A stamp taken at second zero reads as not timing; a
    // warm finish, a recheck restart, a wrapped elapsed time giving an
    // overtime, then the drip timeout.
    task automatic test_stamp_at_zero();
        send_word(make_word(16'd0, 1'b1, 1'b0, -128, 16'd0));
        send_word(make_word(16'd500, 1'b1, 1'b0, -5, 16'd100));
        send_word(make_word(16'd600, 1'b1, 1'b0, 11, 16'd100));
        send_word(make_word(16'd700, 1'b1, 1'b0, -1, 16'd0));
        send_word(make_word(16'd730, 1'b1, 1'b0, 0, 16'd0));
        send_word(make_word(16'd200, 1'b1, 1'b0, -20, 16'd0));
        send_word(make_word(16'd300, 1'b1, 1'b0, -20, 16'd0));
        send_word(make_word(16'd1200, 1'b1, 1'b0, -20, 16'd0));
    endtask

    // Short timeout with a limit of one: the overtime latches the error with
    // a beep, then a warm finish clears it.
    task automatic test_overtime_latch();
        wait_drained();
        write_reg(dhs_pkg::CFG_HEATER_TIMEOUT, 16'd5);
        write_reg(dhs_pkg::CFG_ERROR_LIMIT, 16'd1);
        write_reg(dhs_pkg::CFG_DRIP_TIMEOUT, 16'd3);
        send_word(make_word(16'd10, 1'b1, 1'b0, -128, 16'd0));
        send_word(make_word(16'd20, 1'b1, 1'b0, -128, 16'd0));
        send_word(make_word(16'd30, 1'b1, 1'b0, -128, 16'd0));
        send_word(make_word(16'd31, 1'b1, 1'b0, -128, 16'd0));
        send_word(make_word(16'd32, 1'b1, 1'b0, 127, 16'd0));
    endtask

    // Sensor fault: finish from drip, start heating, hold while under half the
    // compressor time, stop above it, then drip out.
    task automatic test_fault_mode();
        wait_drained();
        write_reg(dhs_pkg::CFG_HEATER_TIMEOUT, 16'd900);
        write_reg(dhs_pkg::CFG_DRIP_TIMEOUT, 16'd600);
        write_reg(dhs_pkg::CFG_FAULT_MIN_ON, 16'd50);
        write_reg(dhs_pkg::CFG_FAULT_MAX_ON, 16'd200);
        send_word(make_word(16'd2000, 1'b1, 1'b1, 0, 16'd0));
        send_word(make_word(16'd2100, 1'b1, 1'b1, 0, 16'd200));
        send_word(make_word(16'd2140, 1'b1, 1'b1, 0, 16'd200));
        send_word(make_word(16'd2160, 1'b1, 1'b1, 0, 16'hFFFF));
        send_word(make_word(16'd2170, 1'b1, 1'b1, 0, 16'd100));
        send_word(make_word(16'd2180, 1'b1, 1'b1, 0, 16'd100));
        send_word(make_word(16'd2900, 1'b1, 1'b1, 0, 16'd100));
    endtask

    // Drive the overtime counter into saturation: with the longest timeout,
    // a full-range wrap of elapsed time overruns it on every heating phase
    // and leaves the on total at zero, so the heater restarts at once.
    task automatic test_overtime_saturation();
        logic [15:0] now_val;
        wait_drained();
        write_reg(dhs_pkg::CFG_HEATER_TIMEOUT, 16'hFFFF);
        write_reg(dhs_pkg::CFG_WARM_THRESHOLD, 16'h007F);
        write_reg(dhs_pkg::CFG_ERROR_LIMIT, 16'h00FF);
        write_reg(dhs_pkg::CFG_DRIP_TIMEOUT, 16'h0000);
        idle_on = 1'b1;
        now_val = 16'd60000;
        repeat (520)
        begin
            if (heat_on)
                now_val = stamp - 16'd1;
            send_word(make_word(now_val, 1'b1, 1'b0, int'($urandom_range(0, 255)) - 128,
                                16'($urandom_range(0, 65535))));
        end
    endtask

    // Hold the result side off for a long stretch while words keep coming,
    // so the block fills and stalls its input.
    task automatic test_backpressure();
        wait_drained();
        idle_on = 1'b0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        repeat (40) send_word(next_random_word());
    endtask

    // Random traffic over several register sets, the extremes among them.
    task automatic test_random_traffic();
        dhs_pkg::cfg_t c;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:
                begin
                    c = '0;
                    c.warm_threshold = 8'h80;
                    c.cold_threshold = 8'h80;
                    c.error_limit    = 8'd1;
                end
                2:
                begin
                    c = '1;
                    c.warm_threshold = 8'h7F;
                    c.cold_threshold = 8'h7F;
                end
                3:
                begin
                    c.heater_timeout = 16'($urandom_range(0, 65535));
                    c.drip_timeout   = 16'($urandom_range(0, 65535));
                    c.recheck_delay  = 16'($urandom_range(0, 65535));
                    c.warm_threshold = 8'($urandom_range(0, 255));
                    c.cold_threshold = 8'($urandom_range(0, 255));
                    c.error_limit    = 8'($urandom_range(1, 255));
                    c.fault_min_on   = 16'($urandom_range(0, 65535));
                    c.fault_max_on   = 16'($urandom_range(0, 65535));
                end
                4:
                begin
                    c.heater_timeout = dhs_pkg::RST_HEATER_TIMEOUT;
                    c.drip_timeout   = dhs_pkg::RST_DRIP_TIMEOUT;
                    c.recheck_delay  = dhs_pkg::RST_RECHECK_DELAY;
                    c.warm_threshold = dhs_pkg::RST_WARM_THRESHOLD;
                    c.cold_threshold = dhs_pkg::RST_COLD_THRESHOLD;
                    c.error_limit    = dhs_pkg::RST_ERROR_LIMIT;
                    c.fault_min_on   = dhs_pkg::RST_FAULT_MIN_ON;
                    c.fault_max_on   = dhs_pkg::RST_FAULT_MAX_ON;
                end
                default:
                begin
                    // Short timers so whole defrost cycles fit in one phase.
                    c.heater_timeout = 16'($urandom_range(0, 200));
                    c.drip_timeout   = 16'($urandom_range(0, 150));
                    c.recheck_delay  = 16'($urandom_range(0, 60));
                    c.warm_threshold = 8'(int'($urandom_range(0, 50)) - 10);
                    c.cold_threshold = 8'(int'($urandom_range(0, 40)) - 30);
                    c.error_limit    = 8'($urandom_range(1, 4));
                    c.fault_min_on   = 16'($urandom_range(0, 100));
                    c.fault_max_on   = 16'($urandom_range(0, 300));
                end
            endcase
            wait_drained();
            write_all(c);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (100) send_word(next_random_word());
        end
    endtask

    // Result side: while idle_on is set, ready drops for a random number of cycles after
    // every accepted result word, and it drops for the whole of a requested hold.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= 1'b1;
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        dhs_pkg::out_item_t got;
        dhs_pkg::out_item_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            got.heater_on        = result_if.heater_on;
            got.defrost_finished = result_if.defrost_finished;
            got.heat_error       = result_if.heat_error;
            got.beep_request     = result_if.beep_request;
            if (expected_words.size() == 0)
                note_mismatch("result word with nothing pending", 0, int'(got));
            else
            begin
                want = expected_words.pop_front();
                if (got.heater_on !== want.heater_on)
                    note_mismatch("heater_on", want.heater_on, got.heater_on);
                if (got.defrost_finished !== want.defrost_finished)
                    note_mismatch("defrost_finished", want.defrost_finished,
                                  got.defrost_finished);
                if (got.heat_error !== want.heat_error)
                    note_mismatch("heat_error", want.heat_error, got.heat_error);
                if (got.beep_request !== want.beep_request)
                    note_mismatch("beep_request", want.beep_request, got.beep_request);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        // Drive every block input to a known level from time zero.
        rst_n                       = 1'b0;
        cfg_wen                     = 1'b0;
        cfg_index                   = dhs_pkg::CFG_HEATER_TIMEOUT;
        cfg_data                    = '0;
        item_if.valid               = 1'b0;
        item_if.now_seconds         = '0;
        item_if.in_defrost          = 1'b0;
        item_if.evap_sensor_fault   = 1'b0;
        item_if.evap_temp           = '0;
        item_if.compressor_run_time = '0;
        result_if.ready             = 1'b0;
        mismatches                  = 0;
        cycle_count                 = 0;
        hold_left                   = 0;
        stall_left                  = 0;
        idle_on                     = 1'b1;
        gen_now                     = 16'd1;
        gen_temp                    = 0;
        gen_fault                   = 1'b0;

        // Shadow state matches the block after reset.
        cfg_copy.heater_timeout = dhs_pkg::RST_HEATER_TIMEOUT;
        cfg_copy.drip_timeout   = dhs_pkg::RST_DRIP_TIMEOUT;
        cfg_copy.recheck_delay  = dhs_pkg::RST_RECHECK_DELAY;
        cfg_copy.warm_threshold = dhs_pkg::RST_WARM_THRESHOLD;
        cfg_copy.cold_threshold = dhs_pkg::RST_COLD_THRESHOLD;
        cfg_copy.error_limit    = dhs_pkg::RST_ERROR_LIMIT;
        cfg_copy.fault_min_on   = dhs_pkg::RST_FAULT_MIN_ON;
        cfg_copy.fault_max_on   = dhs_pkg::RST_FAULT_MAX_ON;
        heat_on                 = 1'b0;
        stamp                   = '0;
        on_acc                  = '0;
        drip_acc                = '0;
        overtime                = '0;
        err_latched             = 1'b0;

        // Hold reset, then release it away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_hold();
        test_stamp_at_zero();
        test_overtime_latch();
        test_fault_mode();
        test_overtime_saturation();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
